>>> rtl/core/multi_timer_table_engine_defines.svh
// Assertion macros shared by the timer table engine RTL.
`ifndef MULTI_TIMER_TABLE_ENGINE_DEFINES_SVH
`define MULTI_TIMER_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define MTTE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define MTTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/mtte_pkg.sv
// Types and constants shared by the timer table engine modules.
`default_nettype none

package mtte_pkg;

    localparam int DUE_W    = 64;
    localparam int PERIOD_W = 31;
    localparam int IDX_W    = 6;
    localparam int REM_W    = 14;
    localparam int DIVISOR  = 10000;

    // Item kinds on the input side.
    localparam logic [1:0] KIND_ARM    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    // Result kinds on the output side.
    localparam logic [1:0] RES_ARM    = 2'd0;
    localparam logic [1:0] RES_CANCEL = 2'd1;
    localparam logic [1:0] RES_EXPIRY = 2'd2;
    localparam logic [1:0] RES_IDLE   = 2'd3;

    // One slot as stored in the slot memory.
    typedef struct packed {
        logic                callback;
        logic [PERIOD_W-1:0] period;
        logic [DUE_W-1:0]    deadline;
    } slot_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RESP,
        ST_SCAN_RD,
        ST_SCAN,
        ST_SCAN_END
    } state_t;

endpackage

`default_nettype wire

>>> rtl/core/mtte_ram.sv
// Generic simple dual-port RAM with a registered read port.
`default_nettype none

module mtte_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [DATA_W-1:0]                     wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [DATA_W-1:0]                     rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/mtte_div.sv
// Divider of a 64-bit value by the tick divisor, settling one 16-bit quotient digit per step.
`default_nettype none

`include "multi_timer_table_engine_defines.svh"

module mtte_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [mtte_pkg::DUE_W-1:0]   dividend,
    output logic                              busy,
    output logic                              done,
    output logic      [mtte_pkg::DUE_W-1:0]   quotient
);

    // Each step divides the running remainder with the next 16 dividend bits appended.
    // A reciprocal multiplication gives the quotient digit of that step exactly, and the
    // following cycle forms the new remainder from it.
    localparam int CHUNK_W = 16;
    localparam int REM_W   = mtte_pkg::REM_W;
    localparam int PART_W  = REM_W + CHUNK_W;
    localparam int RECIP_W = 31;
    localparam int PROD_W  = PART_W + RECIP_W;
    localparam int SHIFT   = PART_W + REM_W;
    localparam int STEPS   = mtte_pkg::DUE_W / CHUNK_W;
    localparam int CNT_W   = $clog2(STEPS);
    localparam logic [CNT_W-1:0]   LAST_STEP = CNT_W'(STEPS - 1);
    localparam logic [PART_W-1:0]  DIV_PART  = PART_W'(mtte_pkg::DIVISOR);
    localparam logic [REM_W-1:0]   REM_LIMIT = REM_W'(mtte_pkg::DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(mtte_pkg::DIVISOR) - 64'd1) / 64'(mtte_pkg::DIVISOR));

    logic [mtte_pkg::DUE_W-1:0] work_reg, work_next;
    logic [mtte_pkg::DUE_W-1:0] quot_reg, quot_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [PART_W-1:0]          part_reg, part_next;
    logic [CHUNK_W-1:0]         digit_reg, digit_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       phase_reg, phase_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [PART_W-1:0]          part;
    logic [PROD_W-1:0]          prod;
    logic [PART_W-1:0]          back;
    logic [PART_W-1:0]          diff;

    // The dividend shifts out at the top while quotient digits shift in at the bottom.
    always_comb
    begin
        part       = {rem_reg, work_reg[mtte_pkg::DUE_W-1 -: CHUNK_W]};
        prod       = PROD_W'(part) * PROD_W'(RECIP);
        back       = PART_W'(digit_reg) * DIV_PART;
        diff       = part_reg - back;
        work_next  = work_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        part_next  = part_reg;
        digit_next = digit_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            work_next  = dividend;
            quot_next  = '0;
            rem_next   = '0;
            cnt_next   = '0;
            phase_next = 1'b0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                part_next  = part;
                digit_next = prod[SHIFT +: CHUNK_W];
                phase_next = 1'b1;
            end
            else
            begin
                rem_next   = diff[REM_W-1:0];
                quot_next  = {quot_reg[mtte_pkg::DUE_W-CHUNK_W-1:0], digit_reg};
                work_next  = {work_reg[mtte_pkg::DUE_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
                cnt_next   = cnt_reg + CNT_W'(1);
                phase_next = 1'b0;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        part_reg  <= part_next;
        digit_reg <= digit_next;
        cnt_reg   <= cnt_next;
        phase_reg <= phase_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quot_reg;

    `MTTE_ASSERT_NOW(a_rem_range, done_reg, rem_reg < REM_LIMIT, "remainder out of range")

endmodule

`default_nettype wire

>>> rtl/core/multi_timer_table_engine.sv
// Top level of the timer table engine: command decode, slot scan and result output.
//
//   Channel   Direction  Handshake               Payload
//   s_axis    in         s_axis_tvalid/tready    tuser = kind, tdata = slot and timing fields
//   m_axis    out        m_axis_tvalid/tready    tuser = result_kind, tdata = status, tlast
//
// An arm item runs a divide of the due time by 10000 that settles one 16-bit quotient digit
// per step. A cancel item goes straight to its result. A tick item makes one slot memory
// read per slot. Each item waits while a full output register is not drained; no item is
// taken until the current one is done.
// Reset clears the tick count, the armed flags and the handshake state; the slot memory
// itself is not cleared, because the entry of a slot is used only while it is armed.
`default_nettype none

`include "multi_timer_table_engine_defines.svh"

module multi_timer_table_engine #(
    parameter int NUM_SLOTS = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata from bit 0: timer_index[5:0], due_time[63:0], period_ms[30:0],
    // has_callback, then two zero pad bits.
    input  wire logic [103:0] s_axis_tdata,
    // tuser: kind[1:0].
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata from bit 0: was_armed, slot_number[5:0], callback_invoked.
    output logic      [7:0]   m_axis_tdata,
    // tuser: result_kind[1:0].
    output logic      [1:0]   m_axis_tuser,
    output logic              m_axis_tlast
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [10:0] SLOT_LIMIT = 11'(NUM_SLOTS);
    localparam int ENTRY_W = $bits(mtte_pkg::slot_entry_t);

    // Input fields as unpacked from the stream.
    logic [mtte_pkg::IDX_W-1:0]    in_idx;
    logic [mtte_pkg::DUE_W-1:0]    in_due;
    logic [mtte_pkg::PERIOD_W-1:0] in_period;
    logic                          in_cb;
    logic                          in_accept;
    logic                          in_rng;

    assign in_idx    = s_axis_tdata[5:0];
    assign in_due    = s_axis_tdata[69:6];
    assign in_period = s_axis_tdata[100:70];
    assign in_cb     = s_axis_tdata[101];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_rng    = ({5'd0, in_idx} < SLOT_LIMIT);

    // Control state.
    mtte_pkg::state_t              state_reg, state_next;
    logic [mtte_pkg::DUE_W-1:0]    tick_reg, tick_next;
    logic [NUM_SLOTS-1:0]          armed_reg, armed_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic                          out_valid_reg, out_valid_next;

    // Payload held for the item in progress.
    logic [1:0]                    kind_reg, kind_next;
    logic [mtte_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic                          neg_reg, neg_next;
    logic [mtte_pkg::PERIOD_W-1:0] period_reg, period_next;
    logic                          cb_reg, cb_next;
    logic                          was_reg, was_next;
    logic [SLOT_W-1:0]             slot_reg, slot_next;
    logic [SLOT_W-1:0]             pend_slot_reg, pend_slot_next;
    logic                          pend_cb_reg, pend_cb_next;

    // Output register.
    logic [1:0]                    out_kind_reg, out_kind_next;
    logic                          out_was_reg, out_was_next;
    logic [mtte_pkg::IDX_W-1:0]    out_slot_reg, out_slot_next;
    logic                          out_cb_reg, out_cb_next;
    logic                          out_last_reg, out_last_next;

    // Divider and slot memory connections.
    logic                          div_start;
    logic                          div_busy;
    logic                          div_done;
    logic [mtte_pkg::DUE_W-1:0]    div_dividend;
    logic [mtte_pkg::DUE_W-1:0]    div_quot;
    logic                          ram_we;
    logic [SLOT_W-1:0]             ram_waddr;
    mtte_pkg::slot_entry_t         ram_wdata;
    logic                          ram_re;
    logic [SLOT_W-1:0]             ram_raddr;
    logic [ENTRY_W-1:0]            ram_rdata;
    mtte_pkg::slot_entry_t         rd_entry;

    // Helpers for the combinational block.
    logic                          out_free;
    logic                          idx_rng;
    logic [mtte_pkg::DUE_W-1:0]    rel_ticks;
    logic [mtte_pkg::DUE_W-1:0]    arm_deadline;
    logic                          slot_due;
    logic                          scan_stall;

    // Helpers for the checks at the end of the module.
    logic                          in_scan;
    logic                          out_mid;
    logic                          out_expiry;
    logic                          ram_both;
    logic                          tick_accept;

    assign out_free     = !out_valid_reg || m_axis_tready;
    assign idx_rng      = ({5'd0, idx_reg} < SLOT_LIMIT);
    assign rd_entry     = mtte_pkg::slot_entry_t'(ram_rdata);
    // A relative due time rounds down but never to zero ticks.
    assign rel_ticks    = (div_quot == '0) ? 64'd1 : div_quot;
    assign arm_deadline = neg_reg ? (tick_reg + rel_ticks) : div_quot;
    assign div_dividend = in_due[63] ? (64'd0 - in_due) : in_due;
    // Deadlines compare as unsigned values against the wrapped tick count.
    assign slot_due     = armed_reg[slot_reg] && (tick_reg >= rd_entry.deadline);
    // A second expiry must push the held one out, which needs room in the output register.
    assign scan_stall   = slot_due && pend_valid_reg && !out_free;

    assign in_scan     = (state_reg == mtte_pkg::ST_SCAN) || (state_reg == mtte_pkg::ST_SCAN_END);
    assign out_mid     = out_valid_reg && !out_last_reg;
    assign out_expiry  = (out_kind_reg == mtte_pkg::RES_EXPIRY);
    assign ram_both    = ram_we && ram_re;
    assign tick_accept = in_accept && (s_axis_tuser == mtte_pkg::KIND_TICK);

    mtte_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    mtte_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (NUM_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mtte_pkg::ST_IDLE;
            tick_reg       <= '0;
            armed_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            armed_reg      <= armed_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        idx_reg       <= idx_next;
        neg_reg       <= neg_next;
        period_reg    <= period_next;
        cb_reg        <= cb_next;
        was_reg       <= was_next;
        slot_reg      <= slot_next;
        pend_slot_reg <= pend_slot_next;
        pend_cb_reg   <= pend_cb_next;
        out_kind_reg  <= out_kind_next;
        out_was_reg   <= out_was_next;
        out_slot_reg  <= out_slot_next;
        out_cb_reg    <= out_cb_next;
        out_last_reg  <= out_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        tick_next       = tick_reg;
        armed_next      = armed_reg;
        pend_valid_next = pend_valid_reg;
        kind_next       = kind_reg;
        idx_next        = idx_reg;
        neg_next        = neg_reg;
        period_next     = period_reg;
        cb_next         = cb_reg;
        was_next        = was_reg;
        slot_next       = slot_reg;
        pend_slot_next  = pend_slot_reg;
        pend_cb_next    = pend_cb_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_was_next    = out_was_reg;
        out_slot_next   = out_slot_reg;
        out_cb_next     = out_cb_reg;
        out_last_next   = out_last_reg;
        s_axis_tready   = 1'b0;
        div_start       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = slot_reg;
        ram_wdata       = rd_entry;
        ram_re          = 1'b0;
        ram_raddr       = slot_reg;

        unique case (state_reg)
            mtte_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_accept)
                begin
                    kind_next   = s_axis_tuser;
                    idx_next    = in_idx;
                    neg_next    = in_due[63];
                    period_next = in_period;
                    cb_next     = in_cb;
                    was_next    = in_rng ? armed_reg[SLOT_W'(in_idx)] : 1'b0;
                    case (s_axis_tuser)
                        mtte_pkg::KIND_ARM:
                        begin
                            div_start  = 1'b1;
                            state_next = mtte_pkg::ST_DIV;
                        end
                        mtte_pkg::KIND_CANCEL:
                        begin
                            if (in_rng)
                            begin
                                armed_next[SLOT_W'(in_idx)] = 1'b0;
                            end
                            state_next = mtte_pkg::ST_RESP;
                        end
                        mtte_pkg::KIND_TICK:
                        begin
                            tick_next  = tick_reg + 64'd1;
                            state_next = mtte_pkg::ST_SCAN_RD;
                        end
                        default:
                        begin
                            state_next = mtte_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            mtte_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    if (idx_rng)
                    begin
                        ram_we             = 1'b1;
                        ram_waddr          = SLOT_W'(idx_reg);
                        ram_wdata.callback = cb_reg;
                        ram_wdata.period   = period_reg;
                        ram_wdata.deadline = arm_deadline;
                        armed_next[SLOT_W'(idx_reg)] = 1'b1;
                    end
                    state_next = mtte_pkg::ST_RESP;
                end
            end

            mtte_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = (kind_reg == mtte_pkg::KIND_ARM) ?
                                     mtte_pkg::RES_ARM : mtte_pkg::RES_CANCEL;
                    out_was_next   = was_reg;
                    out_slot_next  = idx_reg;
                    out_cb_next    = 1'b0;
                    out_last_next  = 1'b1;
                    state_next     = mtte_pkg::ST_IDLE;
                end
            end

            mtte_pkg::ST_SCAN_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                slot_next  = '0;
                state_next = mtte_pkg::ST_SCAN;
            end

            mtte_pkg::ST_SCAN:
            begin
                // The memory output holds the entry of slot_reg until the scan moves on.
                if (!scan_stall)
                begin
                    if (slot_due)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = mtte_pkg::RES_EXPIRY;
                            out_was_next   = 1'b0;
                            out_slot_next  = mtte_pkg::IDX_W'(pend_slot_reg);
                            out_cb_next    = pend_cb_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = slot_reg;
                        pend_cb_next    = rd_entry.callback;
                        if (rd_entry.period != '0)
                        begin
                            ram_we             = 1'b1;
                            ram_waddr          = slot_reg;
                            ram_wdata.deadline = tick_reg + 64'(rd_entry.period);
                        end
                        else
                        begin
                            armed_next[slot_reg] = 1'b0;
                        end
                    end
                    if (slot_reg == LAST_SLOT)
                    begin
                        state_next = mtte_pkg::ST_SCAN_END;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = slot_reg + SLOT_W'(1);
                        slot_next = slot_reg + SLOT_W'(1);
                    end
                end
            end

            mtte_pkg::ST_SCAN_END:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_was_next    = 1'b0;
                    out_last_next   = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_kind_next = mtte_pkg::RES_EXPIRY;
                        out_slot_next = mtte_pkg::IDX_W'(pend_slot_reg);
                        out_cb_next   = pend_cb_reg;
                    end
                    else
                    begin
                        out_kind_next = mtte_pkg::RES_IDLE;
                        out_slot_next = '0;
                        out_cb_next   = 1'b0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = mtte_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mtte_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_cb_reg, out_slot_reg, out_was_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    `MTTE_ASSERT_NOW(a_pend_in_scan, pend_valid_reg, in_scan, "held expiry outside a scan")
    `MTTE_ASSERT_NOW(a_mid_is_expiry, out_mid, out_expiry, "early result not an expiry")
    `MTTE_ASSERT_NOW(a_ram_apart, ram_both, ram_waddr != ram_raddr, "read and write on one entry")
    `MTTE_ASSERT_NOW(a_div_start_idle, div_start, !div_busy, "divider started while busy")
    `MTTE_ASSERT_NEXT(a_tick_step, tick_accept, tick_reg == $past(tick_reg) + 64'd1, "tick lost")

endmodule

`default_nettype wire

>>> verif/timer_table_scoreboard_pkg.sv
// Scoreboard package for the timer table engine: result prediction and in-order checking.
`timescale 1ns / 100ps

package timer_table_scoreboard_pkg;

    import mtte_pkg::*;

    localparam int SLOT_COUNT = 64;

    typedef struct packed {
        logic [1:0] kind;
        logic       was_armed;
        logic [5:0] slot;
        logic       callback;
        logic       last;
    } timer_result_t;

    class timer_table_scoreboard;

        // Shadow copy of the engine state.
        bit [63:0] tick_count;
        bit        slot_live [SLOT_COUNT];
        bit [63:0] slot_due [SLOT_COUNT];
        bit [30:0] slot_reload [SLOT_COUNT];
        bit        slot_cb [SLOT_COUNT];

        timer_result_t awaited_results[$];
        int            failures;

        // Works out the results of one accepted item and queues them.
        function void note_item(logic [1:0] kind, logic [5:0] idx, logic [63:0] due,
                                logic [30:0] period, logic callback);
            timer_result_t res;
            bit [63:0]     magnitude;
            bit [63:0]     rel_ticks;
            int            fired;
            res = '0;
            fired = 0;
            if (kind == KIND_ARM || kind == KIND_CANCEL)
            begin
                res.kind = (kind == KIND_ARM) ? RES_ARM : RES_CANCEL;
                res.was_armed = slot_live[idx];
                res.slot = idx;
                res.last = 1'b1;
                if (kind == KIND_ARM)
                begin
                    if (due[63])
                    begin
                        // Relative due time; the most negative value wraps to 2^63.
                        magnitude = 64'd0 - due;
                        rel_ticks = magnitude / 64'd10000;
                        if (rel_ticks == 64'd0)
                            rel_ticks = 64'd1;
                        slot_due[idx] = tick_count + rel_ticks;
                    end
                    else
                    begin
                        slot_due[idx] = due / 64'd10000;
                    end
                    slot_reload[idx] = period;
                    slot_cb[idx] = callback;
                    slot_live[idx] = 1'b1;
                end
                else
                begin
                    slot_live[idx] = 1'b0;
                end
                awaited_results.push_back(res);
            end
            else if (kind == KIND_TICK)
            begin
                tick_count = tick_count + 64'd1;
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (slot_live[i] && tick_count >= slot_due[i])
                    begin
                        res = '0;
                        res.kind = RES_EXPIRY;
                        res.slot = 6'(i);
                        res.callback = slot_cb[i];
                        awaited_results.push_back(res);
                        fired++;
                        if (slot_reload[i] != 31'd0)
                            slot_due[i] = tick_count + 64'(slot_reload[i]);
                        else
                            slot_live[i] = 1'b0;
                    end
                end
                if (fired == 0)
                begin
                    res = '0;
                    res.kind = RES_IDLE;
                    res.last = 1'b1;
                    awaited_results.push_back(res);
                end
                else
                begin
                    res = awaited_results[awaited_results.size() - 1];
                    res.last = 1'b1;
                    awaited_results[awaited_results.size() - 1] = res;
                end
            end
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s wrong, expected %0d, actual %0d", $time, field, want, got);
                failures++;
            end
        endfunction

        // Compares one accepted result with the oldest awaited one.
        function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
            timer_result_t want;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result not awaited, expected none, actual kind %0d data %h last %0d",
                         $time, kind, data, last);
                failures++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("result_kind", 8'(want.kind), 8'(kind));
            compare_field("was_armed", 8'(want.was_armed), 8'(data[0]));
            compare_field("slot_number", 8'(want.slot), 8'(data[6:1]));
            compare_field("callback_invoked", 8'(want.callback), 8'(data[7]));
            compare_field("last", 8'(want.last), 8'(last));
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction

    endclass

endpackage

>>> verif/tb_top.sv
// Testbench top: drives arm, cancel and tick items into the timer table engine and checks results.
`timescale 1ns / 100ps

module tb_top;

    import mtte_pkg::*;
    import timer_table_scoreboard_pkg::*;

    // Kind code that the engine must drop without a result.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int OUTPUT_HOLD_CYCLES = 300;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    // Phase controls: steady sides never idle, hold request starves the output.
    bit sender_steady;
    bit receiver_steady;
    bit hold_output_req;

    timer_table_scoreboard timer_sb = new;

    multi_timer_table_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("multi_timer_table_engine: mismatch");
        $finish;
    end

    // Offers one item after a random gap, none while the sender is steady, and notes it once taken.
    task automatic send_item(logic [1:0] kind, logic [5:0] idx, logic [63:0] due,
                             logic [30:0] period, logic callback);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = kind;
        s_axis_tdata = {2'b00, callback, period, due, idx};
        do @(posedge clk); while (!s_axis_tready);
        timer_sb.note_item(kind, idx, due, period, callback);
    endtask

    // Random item biased toward due times near the current tick count.
    task automatic send_random_item();
        logic [1:0]  kind;
        logic [63:0] due;
        logic [30:0] period;
        int          pick;
        pick = $urandom_range(0, 19);
        if (pick < 7)
            kind = KIND_ARM;
        else if (pick < 10)
            kind = KIND_CANCEL;
        else if (pick < 19)
            kind = KIND_TICK;
        else
            kind = KIND_UNUSED;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            due = 64'd0 - 64'($urandom_range(0, 60000));
        else if (pick < 6)
            due = timer_sb.tick_count * 64'd10000 + 64'($urandom_range(0, 60000));
        else
            due = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (pick < 5)
            period = 31'd0;
        else if (pick < 8)
            period = 31'($urandom_range(1, 4));
        else
            period = 31'($urandom);
        send_item(kind, 6'($urandom_range(0, 63)), due, period, 1'($urandom));
    endtask

    // Result side: random stall per item, plus one long hold on request.
    initial
    begin : result_sink
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_output_req)
            begin
                m_axis_tready = 1'b0;
                repeat (OUTPUT_HOLD_CYCLES) @(negedge clk);
                hold_output_req = 1'b0;
            end
            else
            begin
                stall = receiver_steady ? 0 : $urandom_range(0, 10);
                if (stall > 0)
                begin
                    m_axis_tready = 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            m_axis_tready = 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            timer_sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = KIND_ARM;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: empty table, deadline forms, field extremes, overdue slots.
        send_item(KIND_TICK, 6'd0, 64'd0, 31'd0, 1'b0);
        send_item(KIND_CANCEL, 6'd0, 64'd0, 31'd0, 1'b0);
        send_item(KIND_ARM, 6'd0, 64'd0, 31'd0, 1'b1);
        // Re-arm an armed slot with a tiny relative time, rounded up to one tick.
        send_item(KIND_ARM, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF, 31'd0, 1'b0);
        send_item(KIND_ARM, 6'd63, 64'd0 - 64'd20000, 31'd1, 1'b1);
        // Most negative due time and largest positive due time with the longest period.
        send_item(KIND_ARM, 6'd32, 64'h8000_0000_0000_0000, 31'd0, 1'b1);
        send_item(KIND_ARM, 6'd31, 64'h7FFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF, 1'b0);
        send_item(KIND_ARM, 6'd1, 64'd20000, 31'd0, 1'b1);
        send_item(KIND_TICK, 6'd0, 64'd0, 31'd0, 1'b0);
        send_item(KIND_TICK, 6'd0, 64'd0, 31'd0, 1'b0);
        send_item(KIND_TICK, 6'd0, 64'd0, 31'd0, 1'b0);
        send_item(KIND_CANCEL, 6'd63, 64'd0, 31'd0, 1'b0);
        send_item(KIND_CANCEL, 6'd32, 64'd0, 31'd0, 1'b0);
        send_item(KIND_UNUSED, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF, 1'b1);
        send_item(KIND_TICK, 6'd0, 64'd0, 31'd0, 1'b0);
        send_item(KIND_ARM, 6'd5, 64'd0 - 64'd10000, 31'h7FFF_FFFF, 1'b1);
        send_item(KIND_TICK, 6'd0, 64'd0, 31'd0, 1'b0);
        // Absolute deadline already in the past fires on the next tick.
        send_item(KIND_ARM, 6'd7, 64'd19999, 31'd0, 1'b0);
        send_item(KIND_TICK, 6'd0, 64'd0, 31'd0, 1'b0);
        send_item(KIND_CANCEL, 6'd31, 64'd0, 31'd0, 1'b0);
        send_item(KIND_CANCEL, 6'd5, 64'd0, 31'd0, 1'b0);

        // Arm every slot at deadline zero so that each slot is due at the next tick.
        sender_steady = 1'b1;
        for (int i = 0; i < SLOT_COUNT; i++)
            send_item(KIND_ARM, 6'(i), 64'($urandom_range(0, 9999)),
                      31'($urandom_range(0, 3)), 1'($urandom));
        sender_steady = 1'b0;

        // Random part, with one burst against a starved output.
        for (int n = 0; n < 28; n++)
        begin
            if (n % 10 == 0)
            begin
                sender_steady = ($urandom_range(0, 3) == 0);
                receiver_steady = ($urandom_range(0, 3) == 0);
            end
            if (n == 20)
            begin
                hold_output_req = 1'b1;
                sender_steady = 1'b1;
                for (int b = 0; b < 8; b++)
                    send_random_item();
                sender_steady = 1'b0;
            end
            send_random_item();
        end

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (timer_sb.outstanding() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (timer_sb.failures == 0)
            $display("multi_timer_table_engine: match");
        else
            $display("multi_timer_table_engine: mismatch");
        $finish;
    end

endmodule
